[hdl/lbs_pkg.sv]
// Shared types and constants for the linear byte buffer line splitter.
package lbs_pkg;

	// Longest read that one item may return.
	localparam int unsigned MAX_READ = 64;

	// Width of the read length field and of the per-read byte counters.
	localparam int unsigned LEN_W = 7;

	// Width of the fill level, count and remaining fields on the ports.
	localparam int unsigned LEVEL_W = 13;

	// Operation codes carried by an input item.
	typedef enum logic [1:0] {
		ACT_RESET      = 2'd0,
		ACT_APPEND     = 2'd1,
		ACT_READ_CHUNK = 2'd2,
		ACT_READ_LINE  = 2'd3
	} action_t;

	// Result status codes.
	typedef enum logic [1:0] {
		STAT_SUCCESS = 2'd0,
		STAT_PARTIAL = 2'd1,
		STAT_FULL    = 2'd2,
		STAT_EMPTY   = 2'd3
	} status_t;

	// States of the execution unit.
	typedef enum logic [2:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_SCAN_ADDR,
		BK_SCAN_DATA,
		BK_EMIT_ADDR,
		BK_EMIT_DATA
	} back_state_t;

	// One classified item as it waits in the queue.
	typedef struct packed {
		action_t              action;
		logic [7:0]           data;
		logic                 chunk_end;
		logic [LEN_W-1:0]     max_len;
		logic [LEVEL_W-1:0]   new_length;
	} lbs_item_t;

endpackage

[hdl/linear_byte_buffer_line_splitter.sv]
// Top level of the linear byte buffer line splitter: register port, front end and back end.
// The back end takes a queued item once it is idle and the output register can take a result,
// and an append (chunk end) or empty-read result is loaded into the output register at that edge.
// Throughput: one append or reset per cycle while the output is not stalled; a read gives its
// bytes one by one from the store read port (a line read first scans them) and blocks new items.
// Reset: after arst_n the store is zeroed by a pass of DEPTH cycles during which in_stall is high.
module linear_byte_buffer_line_splitter
	import lbs_pkg::*;
#(
	parameter int unsigned DEPTH = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         action,
	input  logic [7:0]         data_in,
	input  logic               chunk_end,
	input  logic [LEN_W-1:0]   max_len,
	input  logic [LEVEL_W-1:0] new_length,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         data_out,
	output logic               data_valid,
	output logic [1:0]         status,
	output logic [LEVEL_W-1:0] byte_count,
	output logic [LEVEL_W-1:0] remaining,
	output logic               last
);

	localparam logic REG_CAPACITY  = 1'b0;
	localparam logic REG_DELIMITER = 1'b1;
	localparam logic [LEVEL_W-1:0] CAPACITY_RST  = 13'd4096;
	localparam logic [7:0]         DELIMITER_RST = 8'd10;

	logic [LEVEL_W-1:0] capacity_q;
	logic [7:0]         delimiter_q;
	logic               cfg_write;
	logic               clearing;
	logic               q_valid;
	lbs_item_t          q_item;
	logic               q_pop;

	// Register port: always ready, written in the access phase.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q  <= CAPACITY_RST;
			delimiter_q <= DELIMITER_RST;
		end else if (cfg_write) begin
			case (paddr[2])
				REG_CAPACITY:  capacity_q  <= pwdata[LEVEL_W-1:0];
				REG_DELIMITER: delimiter_q <= pwdata[7:0];
				default:       capacity_q  <= capacity_q;
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		case (paddr[2])
			REG_CAPACITY:  prdata = 32'(capacity_q);
			REG_DELIMITER: prdata = 32'(delimiter_q);
			default:       prdata = '0;
		endcase
	end

	lbs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.action     (action),
		.data_in    (data_in),
		.chunk_end  (chunk_end),
		.max_len    (max_len),
		.new_length (new_length),
		.clearing   (clearing),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_pop      (q_pop)
	);

	lbs_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_pop      (q_pop),
		.clearing   (clearing),
		.capacity   (capacity_q),
		.delimiter  (delimiter_q),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.data_out   (data_out),
		.data_valid (data_valid),
		.status     (status),
		.byte_count (byte_count),
		.remaining  (remaining),
		.last       (last)
	);

	// No item enters while the store is being cleared.
	a_clear_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> in_stall)
		else $error("item accepted during store clearing");

	// A result that carries a byte belongs to a read that returned data.
	a_byte_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && data_valid) |->
			((status == STAT_SUCCESS || status == STAT_PARTIAL) && byte_count != '0))
		else $error("byte result with wrong status or zero count");

	// Results without a byte are the only result of their operation.
	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !data_valid) |-> last)
		else $error("byte-less result not marked last");

	// An empty read reports nothing stored and nothing left.
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == STAT_EMPTY) |-> (byte_count == '0 && remaining == '0))
		else $error("empty result with nonzero counts");

endmodule

[hdl/lbs_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module lbs_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[hdl/lbs_front.sv]
// Front end: accepts input items, normalizes the read length and queues them.
module lbs_front
	import lbs_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         action,
	input  logic [7:0]         data_in,
	input  logic               chunk_end,
	input  logic [LEN_W-1:0]   max_len,
	input  logic [LEVEL_W-1:0] new_length,
	input  logic               clearing,
	output logic               q_valid,
	output lbs_item_t          q_item,
	input  logic               q_pop
);

	lbs_item_t        slot_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             accept;
	lbs_item_t        item_c;
	logic [LEN_W-1:0] len_c;

	// Hold off new items while the queue is full or the store is being cleared.
	assign in_stall = (count_q == 2'd2) || clearing;
	assign accept   = in_valid && !in_stall;

	// Clamp the read length into the supported range.
	always_comb begin
		if (max_len == '0) begin
			len_c = LEN_W'(1);
		end else if (max_len > LEN_W'(MAX_READ)) begin
			len_c = LEN_W'(MAX_READ);
		end else begin
			len_c = max_len;
		end
		item_c.action     = action_t'(action);
		item_c.data       = data_in;
		item_c.chunk_end  = chunk_end;
		item_c.max_len    = len_c;
		item_c.new_length = new_length;
	end

	// Queue storage.
	always_ff @(posedge clk) begin
		if (accept) begin
			slot_q[wr_ptr_q] <= item_c;
		end
	end

	// Queue pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (accept) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({accept, q_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign q_valid = (count_q != 2'd0);
	assign q_item  = slot_q[rd_ptr_q];

endmodule

[hdl/lbs_back.sv]
// Back end: owns the byte store, fill level and read position, and runs each operation.
module lbs_back
	import lbs_pkg::*;
#(
	parameter int unsigned DEPTH = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  lbs_item_t          q_item,
	output logic               q_pop,
	output logic               clearing,
	input  logic [LEVEL_W-1:0] capacity,
	input  logic [7:0]         delimiter,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         data_out,
	output logic               data_valid,
	output logic [1:0]         status,
	output logic [LEVEL_W-1:0] byte_count,
	output logic [LEVEL_W-1:0] remaining,
	output logic               last
);

	localparam int unsigned AW   = $clog2(DEPTH);
	localparam int unsigned LW   = $clog2(DEPTH + 1);
	localparam int unsigned CW   = (LW > LEVEL_W) ? LW : LEVEL_W;

	back_state_t        state_q, state_d;
	logic [CW-1:0]      fill_q, fill_d;
	logic [CW-1:0]      rp_q, rp_d;
	logic               chunk_active_q, chunk_active_d;
	logic [CW-1:0]      chunk_stored_q, chunk_stored_d;
	logic               chunk_blocked_q, chunk_blocked_d;
	logic               chunk_trunc_q, chunk_trunc_d;
	logic [AW-1:0]      clr_q, clr_d;
	logic [LEN_W-1:0]   idx_q, idx_d;
	logic [LEN_W-1:0]   n_q, n_d;
	logic [LEN_W-1:0]   ml_q, ml_d;
	status_t            rstat_q, rstat_d;

	logic               out_valid_q, out_valid_d;
	logic [7:0]         out_byte_q, out_byte_d;
	logic               out_dv_q, out_dv_d;
	status_t            out_stat_q, out_stat_d;
	logic [LEVEL_W-1:0] out_count_q, out_count_d;
	logic [LEVEL_W-1:0] out_rem_q, out_rem_d;
	logic               out_last_q, out_last_d;

	logic               we;
	logic [AW-1:0]      waddr;
	logic [7:0]         wdata;
	logic [AW-1:0]      raddr;
	logic [7:0]         rdata;
	logic [CW-1:0]      rd_sum;

	logic [CW-1:0]      cap;
	logic [CW-1:0]      avail;
	logic               out_free;
	logic [LEN_W-1:0]   k1;
	logic               blocked_c;
	logic               trunc_c;
	logic [CW-1:0]      stored_c;
	logic [CW-1:0]      fill_c;
	logic [CW-1:0]      newlen_c;

	// Byte store.
	lbs_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Working values shared by several states.
	assign cap      = (CW'(capacity) > CW'(DEPTH)) ? CW'(DEPTH) : CW'(capacity);
	assign avail    = fill_q - rp_q;
	assign out_free = !out_valid_q || !out_stall;
	assign k1       = idx_q + LEN_W'(1);
	assign rd_sum   = rp_q + CW'(idx_q);
	assign raddr    = rd_sum[AW-1:0];
	assign newlen_c = CW'(q_item.new_length);
	assign clearing = (state_q == BK_CLEAR);

	// Next state, store writes and result formation.
	always_comb begin
		state_d         = state_q;
		fill_d          = fill_q;
		rp_d            = rp_q;
		chunk_active_d  = chunk_active_q;
		chunk_stored_d  = chunk_stored_q;
		chunk_blocked_d = chunk_blocked_q;
		chunk_trunc_d   = chunk_trunc_q;
		clr_d           = clr_q;
		idx_d           = idx_q;
		n_d             = n_q;
		ml_d            = ml_q;
		rstat_d         = rstat_q;
		out_valid_d     = out_valid_q && out_stall;
		out_byte_d      = out_byte_q;
		out_dv_d        = out_dv_q;
		out_stat_d      = out_stat_q;
		out_count_d     = out_count_q;
		out_rem_d       = out_rem_q;
		out_last_d      = out_last_q;
		we              = 1'b0;
		waddr           = fill_q[AW-1:0];
		wdata           = q_item.data;
		q_pop           = 1'b0;
		blocked_c       = chunk_active_q ? chunk_blocked_q : (fill_q >= cap);
		trunc_c         = chunk_active_q && chunk_trunc_q;
		stored_c        = chunk_active_q ? chunk_stored_q : '0;
		fill_c          = fill_q;

		case (state_q)
			// Zero the store one entry per cycle after reset.
			BK_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = 8'd0;
				clr_d = clr_q + AW'(1);
				if (clr_q == AW'(DEPTH - 1)) begin
					state_d = BK_IDLE;
				end
			end

			// Take the next queued item once the output register can take a result.
			BK_IDLE: begin
				if (q_valid && out_free) begin
					q_pop = 1'b1;
					case (q_item.action)
						ACT_RESET: begin
							fill_d          = (newlen_c > cap) ? cap : newlen_c;
							rp_d            = '0;
							chunk_active_d  = 1'b0;
							chunk_stored_d  = '0;
							chunk_blocked_d = 1'b0;
							chunk_trunc_d   = 1'b0;
						end
						ACT_APPEND: begin
							if (!blocked_c) begin
								if (fill_q < cap) begin
									we       = 1'b1;
									fill_c   = fill_q + CW'(1);
									stored_c = stored_c + CW'(1);
								end else begin
									trunc_c = 1'b1;
								end
							end
							fill_d = fill_c;
							if (q_item.chunk_end) begin
								out_valid_d     = 1'b1;
								out_byte_d      = 8'd0;
								out_dv_d        = 1'b0;
								out_stat_d      = blocked_c ? STAT_FULL :
									(trunc_c ? STAT_PARTIAL : STAT_SUCCESS);
								out_count_d     = blocked_c ? '0 : stored_c[LEVEL_W-1:0];
								out_rem_d       = LEVEL_W'(fill_c - rp_q);
								out_last_d      = 1'b1;
								chunk_active_d  = 1'b0;
								chunk_stored_d  = '0;
								chunk_blocked_d = 1'b0;
								chunk_trunc_d   = 1'b0;
							end else begin
								chunk_active_d  = 1'b1;
								chunk_stored_d  = stored_c;
								chunk_blocked_d = blocked_c;
								chunk_trunc_d   = trunc_c;
							end
						end
						ACT_READ_CHUNK, ACT_READ_LINE: begin
							idx_d = '0;
							ml_d  = q_item.max_len;
							if (avail == '0) begin
								out_valid_d = 1'b1;
								out_byte_d  = 8'd0;
								out_dv_d    = 1'b0;
								out_stat_d  = STAT_EMPTY;
								out_count_d = '0;
								out_rem_d   = '0;
								out_last_d  = 1'b1;
							end else if (q_item.action == ACT_READ_CHUNK) begin
								if (avail > CW'(q_item.max_len)) begin
									n_d     = q_item.max_len;
									rstat_d = STAT_SUCCESS;
								end else begin
									n_d     = avail[LEN_W-1:0];
									rstat_d = STAT_PARTIAL;
								end
								state_d = BK_EMIT_ADDR;
							end else begin
								state_d = BK_SCAN_ADDR;
							end
						end
						default: begin
							state_d = BK_IDLE;
						end
					endcase
				end
			end

			// Line read: the store address is presented this cycle.
			BK_SCAN_ADDR: begin
				state_d = BK_SCAN_DATA;
			end

			// Line read: test the fetched byte and decide the line length.
			BK_SCAN_DATA: begin
				if (rdata == delimiter) begin
					n_d     = k1;
					rstat_d = STAT_SUCCESS;
					idx_d   = '0;
					state_d = BK_EMIT_ADDR;
				end else if ((k1 == ml_q) || (CW'(k1) == avail)) begin
					n_d     = k1;
					rstat_d = STAT_PARTIAL;
					idx_d   = '0;
					state_d = BK_EMIT_ADDR;
				end else begin
					idx_d   = k1;
					state_d = BK_SCAN_ADDR;
				end
			end

			// Emit: the store address is presented this cycle.
			BK_EMIT_ADDR: begin
				state_d = BK_EMIT_DATA;
			end

			// Emit: hand the fetched byte to the output register.
			BK_EMIT_DATA: begin
				if (out_free) begin
					out_valid_d = 1'b1;
					out_byte_d  = rdata;
					out_dv_d    = 1'b1;
					out_stat_d  = rstat_q;
					out_count_d = LEVEL_W'(n_q);
					out_rem_d   = LEVEL_W'(avail - CW'(n_q));
					out_last_d  = (k1 == n_q);
					if (k1 == n_q) begin
						rp_d    = rp_q + CW'(n_q);
						state_d = BK_IDLE;
					end else begin
						idx_d   = k1;
						state_d = BK_EMIT_ADDR;
					end
				end
			end

			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= BK_CLEAR;
			fill_q          <= '0;
			rp_q            <= '0;
			chunk_active_q  <= 1'b0;
			chunk_stored_q  <= '0;
			chunk_blocked_q <= 1'b0;
			chunk_trunc_q   <= 1'b0;
			clr_q           <= '0;
			idx_q           <= '0;
			n_q             <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			state_q         <= state_d;
			fill_q          <= fill_d;
			rp_q            <= rp_d;
			chunk_active_q  <= chunk_active_d;
			chunk_stored_q  <= chunk_stored_d;
			chunk_blocked_q <= chunk_blocked_d;
			chunk_trunc_q   <= chunk_trunc_d;
			clr_q           <= clr_d;
			idx_q           <= idx_d;
			n_q             <= n_d;
			out_valid_q     <= out_valid_d;
		end
	end

	// Operation and result payload.
	always_ff @(posedge clk) begin
		ml_q        <= ml_d;
		rstat_q     <= rstat_d;
		out_byte_q  <= out_byte_d;
		out_dv_q    <= out_dv_d;
		out_stat_q  <= out_stat_d;
		out_count_q <= out_count_d;
		out_rem_q   <= out_rem_d;
		out_last_q  <= out_last_d;
	end

	assign out_valid  = out_valid_q;
	assign data_out   = out_byte_q;
	assign data_valid = out_dv_q;
	assign status     = out_stat_q;
	assign byte_count = out_count_q;
	assign remaining  = out_rem_q;
	assign last       = out_last_q;

endmodule
